@@ hdl/ctc_pkg.sv @@
`timescale 1ns / 1ps

package ctc_pkg;

    localparam int MAX_TEXT    = 32;
    localparam int MAX_KEY     = 8;

    localparam int BYTE_W      = 8;
    localparam int KEY_CHARS_W = 64;
    localparam int KEY_W       = 4;
    localparam int CNT_W       = $clog2(MAX_TEXT + 1);
    localparam int COL_W       = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
    localparam int IDX_W       = $clog2(MAX_TEXT + MAX_KEY);
    localparam int AW          = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
    localparam int RAM_AW      = AW + 1;
    localparam int RAM_DEPTH   = 1 << RAM_AW;
    localparam int STEP_W      = (CNT_W > 1) ? $clog2(CNT_W) : 1;
    localparam int DIV_W       = CNT_W + KEY_W;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_CHARS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 2'd2;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h5F;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
        logic              overflow;
    } out_item_t;

    typedef struct packed {
        logic [KEY_CHARS_W-1:0] key_chars;
        logic [KEY_W-1:0]       key_length;
        logic                   direction;
    } cfg_t;

    // One finished message waiting for the back end.
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             dropped;
    } job_t;

    // The back end hands a bank back to the front end.
    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

endpackage

@@ hdl/ctc_ram.sv @@
`timescale 1ns / 1ps

module ctc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/ctc_front.sv @@
`timescale 1ns / 1ps

module ctc_front import ctc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    input  logic              q_full,
    output logic              q_push,
    output job_t              q_job,
    input  rel_t              rel,
    output logic              ram_we,
    output logic [RAM_AW-1:0] ram_waddr,
    output logic [BYTE_W-1:0] ram_wdata
);

    logic             bank_reg, bank_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic [1:0]       busy_reg, busy_next;

    logic             accept;
    logic             room;
    logic [CNT_W-1:0] count_after;
    logic             dropped_after;

    // A bank stays busy from the final byte until the back end has read it out.
    assign in_stall = busy_reg[bank_reg] || q_full;
    assign accept   = in_valid && !in_stall;
    assign room     = count_reg < CNT_W'(MAX_TEXT);

    assign count_after   = room ? count_reg + CNT_W'(1) : count_reg;
    assign dropped_after = dropped_reg || !room;

    assign ram_we    = accept && room;
    assign ram_waddr = {bank_reg, count_reg[AW-1:0]};
    assign ram_wdata = in_data.in_byte;

    assign q_push = accept && in_data.in_last;
    assign q_job  = '{bank: bank_reg, count: count_after, dropped: dropped_after};

    always_comb
    begin
        bank_next    = bank_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        busy_next    = busy_reg;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (accept)
        begin
            if (in_data.in_last)
            begin
                busy_next[bank_reg] = 1'b1;
                bank_next           = !bank_reg;
                count_next          = '0;
                dropped_next        = 1'b0;
            end
            else
            begin
                count_next   = count_after;
                dropped_next = dropped_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg    <= 1'b0;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            busy_reg    <= '0;
        end
        else
        begin
            bank_reg    <= bank_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            busy_reg    <= busy_next;
        end
    end

endmodule

@@ hdl/ctc_queue.sv @@
`timescale 1ns / 1ps

module ctc_queue import ctc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t pop_job,
    output logic full,
    output logic empty
);

    job_t              q_mem_reg [QDEPTH];
    job_t              q_mem_next [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full    = cnt_reg == QCNT_W'(QDEPTH);
    assign empty   = cnt_reg == '0;
    assign pop_job = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        q_mem_next  = q_mem_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            q_mem_next[wr_ptr_reg] = push_job;
            wr_ptr_next            = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        priority if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        q_mem_reg <= q_mem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ hdl/ctc_back.sv @@
`timescale 1ns / 1ps

module ctc_back import ctc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              q_empty,
    input  job_t              q_job,
    output logic              q_pop,
    output logic              ram_re,
    output logic [RAM_AW-1:0] ram_raddr,
    input  logic [BYTE_W-1:0] ram_rdata,
    output rel_t              rel,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    // Control
    logic [2:0]        state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic              hold_valid_reg, hold_valid_next;

    // Payload
    out_item_t         out_data_reg, out_data_next;
    logic [BYTE_W-1:0] hold_byte_reg, hold_byte_next;
    logic              bank_reg, bank_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic              drop_reg, drop_next;
    logic [KEY_W-1:0]  k_reg, k_next;
    logic              dir_reg, dir_next;
    logic [COL_W-1:0]  rank_reg [MAX_KEY];
    logic [COL_W-1:0]  rank_next [MAX_KEY];
    logic [COL_W-1:0]  order_reg [MAX_KEY];
    logic [COL_W-1:0]  order_next [MAX_KEY];
    logic [IDX_W-1:0]  base_reg [MAX_KEY];
    logic [IDX_W-1:0]  base_next [MAX_KEY];
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  rows_reg, rows_next;
    logic [COL_W-1:0]  col_cnt_reg, col_cnt_next;
    logic [CNT_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [IDX_W-1:0]  row_base_reg, row_base_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    logic [KEY_W-1:0]  k_eff;
    logic [COL_W-1:0]  rank_c [MAX_KEY];
    logic [COL_W-1:0]  order_c [MAX_KEY];
    logic [DIV_W-1:0]  shifted;
    logic              ge;
    logic [CNT_W-1:0]  rows_c;
    logic [IDX_W-1:0]  idx_c;
    logic              can_load;
    logic              col_last;
    logic              row_last;
    logic              pad_hit;
    logic              keep;
    logic [BYTE_W-1:0] cand;
    logic              rel_valid;

    always_comb
    begin
        priority if (cfg.key_length == '0)
        begin
            k_eff = KEY_W'(1);
        end
        else if (cfg.key_length > KEY_W'(MAX_KEY))
        begin
            k_eff = KEY_W'(MAX_KEY);
        end
        else
        begin
            k_eff = cfg.key_length;
        end
    end

    // Equal key characters are ranked by position, the earlier one first.
    always_comb
    begin
        logic [COL_W:0]    acc;
        logic [BYTE_W-1:0] ch_i;
        logic [BYTE_W-1:0] ch_j;
        for (int j = 0; j < MAX_KEY; j++)
        begin
            acc  = '0;
            ch_j = cfg.key_chars[BYTE_W*j +: BYTE_W];
            for (int i = 0; i < MAX_KEY; i++)
            begin
                ch_i = cfg.key_chars[BYTE_W*i +: BYTE_W];
                if ((KEY_W'(i) < k_eff) && ((ch_i < ch_j) || ((ch_i == ch_j) && (i < j))))
                begin
                    acc = acc + (COL_W + 1)'(1);
                end
            end
            rank_c[j] = COL_W'(acc);
        end
    end

    always_comb
    begin
        for (int m = 0; m < MAX_KEY; m++)
        begin
            order_c[m] = '0;
            for (int j = 0; j < MAX_KEY; j++)
            begin
                if ((KEY_W'(j) < k_reg) && (rank_reg[j] == COL_W'(m)))
                begin
                    order_c[m] = COL_W'(j);
                end
            end
        end
    end

    assign shifted = DIV_W'(k_reg) << step_reg;
    assign ge      = DIV_W'(rem_reg) >= shifted;
    assign rows_c  = (dir_reg == DIR_DECRYPT) ? quo_reg
                                              : quo_reg + CNT_W'(rem_reg != '0);

    // Encryption walks a column top to bottom; decryption walks a row across
    // the columns, each column sitting at rank times rows in the ciphertext.
    assign idx_c = (dir_reg == DIR_ENCRYPT)
                   ? row_base_reg + IDX_W'(order_reg[col_cnt_reg])
                   : base_reg[col_cnt_reg] + IDX_W'(row_cnt_reg);

    assign ram_re    = state_reg == S_RD;
    assign ram_raddr = {bank_reg, idx_c[AW-1:0]};

    assign can_load = !out_valid_reg || !out_stall;
    assign col_last = (KEY_W'(col_cnt_reg) + KEY_W'(1)) == k_reg;
    assign row_last = (row_cnt_reg + CNT_W'(1)) == rows_reg;
    assign pad_hit  = idx_reg >= IDX_W'(n_reg);
    assign keep     = (dir_reg == DIR_ENCRYPT) || (ram_rdata != PAD_BYTE);
    assign cand     = ((dir_reg == DIR_ENCRYPT) && pad_hit) ? PAD_BYTE : ram_rdata;

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        hold_valid_next = hold_valid_reg;
        out_data_next   = out_data_reg;
        hold_byte_next  = hold_byte_reg;
        bank_next       = bank_reg;
        n_next          = n_reg;
        drop_next       = drop_reg;
        k_next          = k_reg;
        dir_next        = dir_reg;
        rank_next       = rank_reg;
        order_next      = order_reg;
        base_next       = base_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        rows_next       = rows_reg;
        col_cnt_next    = col_cnt_reg;
        row_cnt_next    = row_cnt_reg;
        row_base_next   = row_base_reg;
        idx_next        = idx_reg;
        q_pop           = 1'b0;
        rel_valid       = 1'b0;

        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    bank_next  = q_job.bank;
                    n_next     = q_job.count;
                    drop_next  = q_job.dropped;
                    k_next     = k_eff;
                    dir_next   = cfg.direction;
                    rank_next  = rank_c;
                    rem_next   = q_job.count;
                    quo_next   = '0;
                    step_next  = STEP_W'(CNT_W - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // Restoring division of the byte count by the column count.
                if (ge)
                begin
                    rem_next = rem_reg - shifted[CNT_W-1:0];
                end
                quo_next = CNT_W'({quo_reg, ge});
                if (step_reg == '0)
                begin
                    state_next = S_PREP;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            S_PREP:
            begin
                rows_next = rows_c;
                for (int j = 0; j < MAX_KEY; j++)
                begin
                    base_next[j] = IDX_W'(rank_reg[j]) * IDX_W'(rows_c);
                end
                order_next    = order_c;
                col_cnt_next  = '0;
                row_cnt_next  = '0;
                row_base_next = '0;
                state_next    = (rows_c == '0) ? S_FLUSH : S_RD;
            end
            S_RD:
            begin
                idx_next   = idx_c;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                // A kept byte is held back one step so that the last one of
                // the run can be marked once the walk is over.
                if (!(keep && hold_valid_reg && !can_load))
                begin
                    if (keep)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '{out_byte: hold_byte_reg, out_last: 1'b0,
                                               overflow: drop_reg};
                        end
                        hold_byte_next  = cand;
                        hold_valid_next = 1'b1;
                    end
                    state_next = S_RD;
                    if (dir_reg == DIR_ENCRYPT)
                    begin
                        if (row_last)
                        begin
                            row_cnt_next  = '0;
                            row_base_next = '0;
                            if (col_last)
                            begin
                                state_next = S_FLUSH;
                            end
                            else
                            begin
                                col_cnt_next = col_cnt_reg + COL_W'(1);
                            end
                        end
                        else
                        begin
                            row_cnt_next  = row_cnt_reg + CNT_W'(1);
                            row_base_next = row_base_reg + IDX_W'(k_reg);
                        end
                    end
                    else
                    begin
                        if (col_last)
                        begin
                            col_cnt_next = '0;
                            if (row_last)
                            begin
                                state_next = S_FLUSH;
                            end
                            else
                            begin
                                row_cnt_next = row_cnt_reg + CNT_W'(1);
                            end
                        end
                        else
                        begin
                            col_cnt_next = col_cnt_reg + COL_W'(1);
                        end
                    end
                end
            end
            S_FLUSH:
            begin
                if (hold_valid_reg)
                begin
                    if (can_load)
                    begin
                        out_valid_next  = 1'b1;
                        out_data_next   = '{out_byte: hold_byte_reg, out_last: 1'b1,
                                            overflow: drop_reg};
                        hold_valid_next = 1'b0;
                        rel_valid       = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    rel_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rel       = '{valid: rel_valid, bank: bank_reg};
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        hold_byte_reg <= hold_byte_next;
        bank_reg      <= bank_next;
        n_reg         <= n_next;
        drop_reg      <= drop_next;
        k_reg         <= k_next;
        dir_reg       <= dir_next;
        rank_reg      <= rank_next;
        order_reg     <= order_next;
        base_reg      <= base_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        step_reg      <= step_next;
        rows_reg      <= rows_next;
        col_cnt_reg   <= col_cnt_next;
        row_cnt_reg   <= row_cnt_next;
        row_base_reg  <= row_base_next;
        idx_reg       <= idx_next;
    end

endmodule

@@ hdl/columnar_transposition_cipher_core.sv @@
`timescale 1ns / 1ps

// Channel  Signals                                   Transfer at rising edge when
// in       in_valid, in_stall, in_data               in_valid && !in_stall
// out      out_valid, out_stall, out_data            out_valid && !out_stall
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// Input bytes are taken one per cycle, unless in_stall is high, into one of two message
// banks of the message RAM. After the final byte the back end takes the message from the
// queue, divides the byte count by the column count, sets up, then reads each grid cell
// through the single RAM read port and checks it, and finally frees the bank. The input
// stalls only while both banks hold messages; an output stall holds the back end. Reset
// is asynchronous, active low, and leaves the registers at key 0, key length 1, encrypt.
// cfg_ready is always high.

module columnar_transposition_cipher_core import ctc_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [KEY_CHARS_W-1:0] cfg_data
);

    logic [KEY_CHARS_W-1:0] key_chars_reg, key_chars_next;
    logic [KEY_W-1:0]       key_length_reg, key_length_next;
    logic                   direction_reg, direction_next;

    cfg_t              cfg;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    job_t              q_in_job;
    job_t              q_out_job;
    rel_t              rel;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [RAM_AW-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        key_chars_next  = key_chars_reg;
        key_length_next = key_length_reg;
        direction_next  = direction_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_KEY_CHARS:  key_chars_next  = cfg_data;
                CFG_KEY_LENGTH: key_length_next = cfg_data[KEY_W-1:0];
                CFG_DIRECTION:  direction_next  = cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_chars_reg  <= '0;
            key_length_reg <= KEY_W'(1);
            direction_reg  <= DIR_ENCRYPT;
        end
        else
        begin
            key_chars_reg  <= key_chars_next;
            key_length_reg <= key_length_next;
            direction_reg  <= direction_next;
        end
    end

    assign cfg = '{key_chars: key_chars_reg, key_length: key_length_reg,
                   direction: direction_reg};

    ctc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_in_job),
        .rel       (rel),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    ctc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_msg_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    ctc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_in_job),
        .pop      (q_pop),
        .pop_job  (q_out_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    ctc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_job     (q_out_job),
        .q_pop     (q_pop),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .rel       (rel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef NO_ASSERTIONS
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("Back end took a message from an empty queue.");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("Front end queued a message into a full queue.");

    a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> in_stall)
        else $error("Input not stalled while the message queue is full.");

    a_release_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !rel.valid)
        else $error("Bank released in the cycle after a message was taken.");
`endif

endmodule

@@ bench/columnar_transposition_cipher_core_tb.sv @@
`timescale 1ns / 1ps

module columnar_transposition_cipher_core_tb;
    import ctc_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RAND_ITEMS   = 380;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 2 * (2 * (MAX_TEXT + MAX_KEY) + 9) + 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DIR_ROWS     = 33;

    // Index 3 is not decoded by the block; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef logic [BYTE_W-1:0] octet_t;

    typedef enum logic [1:0] {CHK_MODEL, CHK_ONE, CHK_NONE} check_e;
    typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_e;
    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

    typedef struct {
        row_kind_e              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [KEY_CHARS_W-1:0] value;
        in_item_t               item;
        check_e                 chk;
        out_item_t              want;
    } stim_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [KEY_CHARS_W-1:0] cfg_data  = '0;

    // Shadow of the block's registers and message buffer.
    logic [KEY_CHARS_W-1:0] key_reg  = '0;
    logic [KEY_W-1:0]       klen_reg = 4'd1;
    logic                   dir_reg  = DIR_ENCRYPT;
    octet_t                 msg_buf [MAX_TEXT];
    int unsigned            msg_len  = 0;
    logic                   msg_drop = 1'b0;

    octet_t      perm_out [$];
    logic        perm_drop;
    out_item_t   cipher_q [$];
    octet_t      msg_q [$];
    stim_row_t   stim_tbl [DIR_ROWS];

    int unsigned errors     = 0;
    int unsigned cycles     = 0;
    int unsigned rand_items = 0;
    int unsigned burst_left = 0;
    bit          dirty      = 1'b0;
    bit          cfg_open   = 1'b0;

    bit          hold_go    = 1'b0;
    bit          hold_done  = 1'b0;
    int unsigned hold_left  = 0;
    int unsigned mode_left  = 0;
    stall_mode_e stall_mode = STALL_NONE;

    columnar_transposition_cipher_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Transposes src[0..n-1] under the given key settings into perm_out.
    function automatic void transpose_msg(input octet_t src [MAX_TEXT], input int unsigned n,
                                          input logic [KEY_CHARS_W-1:0] key,
                                          input logic [KEY_W-1:0] klen, input logic dir);
        int unsigned cols;
        int unsigned rows;
        int unsigned idx;
        int unsigned r_cnt;
        int unsigned rank [MAX_KEY];
        int unsigned order [MAX_KEY];
        octet_t      ch [MAX_KEY];
        perm_out.delete();
        cols = (klen == 0) ? 1 : ((klen > MAX_KEY) ? MAX_KEY : klen);
        for (int j = 0; j < cols; j++)
            ch[j] = key[8 * j +: 8];
        // Equal key characters keep their positional order.
        for (int j = 0; j < cols; j++)
        begin
            r_cnt = 0;
            for (int i = 0; i < cols; i++)
                if (ch[i] < ch[j] || (ch[i] == ch[j] && i < j))
                    r_cnt++;
            rank[j]      = r_cnt;
            order[r_cnt] = j;
        end
        if (dir == DIR_ENCRYPT)
        begin
            rows = (n + cols - 1) / cols;
            for (int m = 0; m < cols; m++)
                for (int r = 0; r < rows; r++)
                begin
                    idx = r * cols + order[m];
                    perm_out.push_back((idx < n) ? src[idx] : PAD_BYTE);
                end
        end
        else
        begin
            // Bytes past the last full row are ignored.
            rows = n / cols;
            for (int r = 0; r < rows; r++)
                for (int j = 0; j < cols; j++)
                begin
                    idx = rank[j] * rows + r;
                    if (src[idx] != PAD_BYTE)
                        perm_out.push_back(src[idx]);
                end
        end
    endfunction

    // Buffers one byte; returns 1 when the message closes and perm_out holds its result.
    function automatic bit take_byte(input in_item_t item);
        if (msg_len < MAX_TEXT)
        begin
            msg_buf[msg_len] = item.in_byte;
            msg_len++;
        end
        else
            msg_drop = 1'b1;
        if (!item.in_last)
            return 1'b0;
        transpose_msg(msg_buf, msg_len, key_reg, klen_reg, dir_reg);
        perm_drop = msg_drop;
        msg_len   = 0;
        msg_drop  = 1'b0;
        return 1'b1;
    endfunction

    function automatic stim_row_t row_wr(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [KEY_CHARS_W-1:0] value);
        stim_row_t row;
        row         = '{kind: ROW_WRITE, reg_idx: idx, value: value, item: '0,
                        chk: CHK_NONE, want: '0};
        return row;
    endfunction

    function automatic stim_row_t row_byte(input octet_t b, input logic last);
        stim_row_t row;
        row         = '{kind: ROW_BYTE, reg_idx: '0, value: '0, item: '0,
                        chk: CHK_MODEL, want: '0};
        row.item.in_byte = b;
        row.item.in_last = last;
        return row;
    endfunction

    // A one-byte message whose outcome is obvious: a single result, or none at all.
    function automatic stim_row_t row_chk(input octet_t b, input check_e chk, input octet_t want_b);
        stim_row_t row;
        row               = row_byte(b, 1'b1);
        row.chk           = chk;
        row.want.out_byte = want_b;
        row.want.out_last = 1'b1;
        row.want.overflow = 1'b0;
        return row;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_CHARS_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_open   = 1'b1;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        case (idx)
            CFG_KEY_CHARS:  key_reg  = value;
            CFG_KEY_LENGTH: klen_reg = value[KEY_W-1:0];
            CFG_DIRECTION:  dir_reg  = value[0];
            default:        ;
        endcase
    endtask

    task automatic send_byte(input in_item_t item, input check_e chk, input out_item_t want);
        int unsigned gap;
        out_item_t   res;
        if (cfg_open)
        begin
            cfg_valid <= 1'b0;
            cfg_open   = 1'b0;
        end
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        burst_left--;
        dirty = 1'b1;
        if (take_byte(item))
            case (chk)
                CHK_MODEL:
                    foreach (perm_out[i])
                    begin
                        res.out_byte = perm_out[i];
                        res.out_last = (i == perm_out.size() - 1);
                        res.overflow = perm_drop;
                        cipher_q.push_back(res);
                    end
                CHK_ONE:  cipher_q.push_back(want);
                default:  ;
            endcase
    endtask

    task automatic send_msg();
        in_item_t item;
        foreach (msg_q[i])
        begin
            item.in_byte = msg_q[i];
            item.in_last = (i == msg_q.size() - 1);
            send_byte(item, CHK_MODEL, '0);
        end
        rand_items += msg_q.size();
    endtask

    // Waits until every expected result has arrived and any message with an empty
    // result has had time to leave the block.
    task automatic drain();
        if (!dirty)
            return;
        in_valid <= 1'b0;
        while (cipher_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        dirty = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_go && !hold_done)
        begin
            // One long hold-off so that both banks fill and the input backs up.
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_e'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 150);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:   out_stall <= 1'b0;
                STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                STALL_TOGGLE: out_stall <= ~out_stall;
            endcase
        end
    end

    // Outputs are settled by the falling edge; a transfer seen here completes at the next rise.
    always @(negedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (cipher_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h/%b/%b", $time,
                         out_data.out_byte, out_data.out_last, out_data.overflow);
                errors++;
            end
            else
            begin
                want = cipher_q.pop_front();
                if (out_data.out_byte !== want.out_byte)
                begin
                    $display("%0t: out_byte mismatch: expected %h, actual %h", $time,
                             want.out_byte, out_data.out_byte);
                    errors++;
                end
                if (out_data.out_last !== want.out_last)
                begin
                    $display("%0t: out_last mismatch: expected %b, actual %b", $time,
                             want.out_last, out_data.out_last);
                    errors++;
                end
                if (out_data.overflow !== want.overflow)
                begin
                    $display("%0t: overflow mismatch: expected %b, actual %b", $time,
                             want.overflow, out_data.overflow);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d results outstanding", $time, cipher_q.size());
            $display("columnar_transposition_cipher_core regression: fail");
            $finish;
        end
    end

    initial
    begin : main
        logic [KEY_CHARS_W-1:0] key;
        logic [KEY_W-1:0]       klen;
        octet_t                 plain [MAX_TEXT];
        int unsigned            len;
        int unsigned            plain_len;
        int unsigned            n_msgs;
        bit                     first_phase;

        stim_tbl = '{
            row_chk(8'h41, CHK_ONE, 8'h41),
            row_chk(8'h00, CHK_ONE, 8'h00),
            row_chk(8'hFF, CHK_ONE, 8'hFF),
            row_wr(CFG_DIRECTION, KEY_CHARS_W'(DIR_DECRYPT)),
            row_chk(PAD_BYTE, CHK_NONE, 8'h00),
            row_chk(8'h80, CHK_ONE, 8'h80),
            row_wr(CFG_KEY_CHARS, 64'h0000_0000_0042_4143),
            row_wr(CFG_KEY_LENGTH, 64'd3),
            row_wr(CFG_DIRECTION, KEY_CHARS_W'(DIR_ENCRYPT)),
            row_byte("H", 1'b0),
            row_byte("E", 1'b0),
            row_byte("L", 1'b0),
            row_byte("L", 1'b0),
            row_byte("O", 1'b1),
            row_wr(CFG_DIRECTION, KEY_CHARS_W'(DIR_DECRYPT)),
            row_byte("H", 1'b0),
            row_byte("L", 1'b0),
            row_byte("E", 1'b0),
            row_byte("L", 1'b0),
            row_byte("O", 1'b0),
            row_byte(PAD_BYTE, 1'b1),
            row_byte("A", 1'b0),
            row_byte("B", 1'b1),
            row_wr(CFG_KEY_LENGTH, 64'd0),
            row_byte(8'h7E, 1'b1),
            row_wr(CFG_KEY_CHARS, 64'h4141_4141_4141_4141),
            row_wr(CFG_KEY_LENGTH, 64'd15),
            row_wr(CFG_DIRECTION, KEY_CHARS_W'(DIR_ENCRYPT)),
            row_byte(8'h01, 1'b0),
            row_byte(8'h02, 1'b0),
            row_byte(8'h03, 1'b1),
            row_wr(CFG_SPARE, '1),
            row_byte(8'h5A, 1'b1)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_tbl[i])
        begin
            if (stim_tbl[i].kind == ROW_WRITE)
            begin
                drain();
                write_reg(stim_tbl[i].reg_idx, stim_tbl[i].value);
            end
            else
                send_byte(stim_tbl[i].item, stim_tbl[i].chk, stim_tbl[i].want);
        end

        first_phase = 1'b1;
        while (rand_items < RAND_ITEMS)
        begin
            drain();
            case ($urandom_range(0, 7))
                0:       key = '0;
                1:       key = '1;
                2, 3:    for (int b = 0; b < MAX_KEY; b++)
                             key[8 * b +: 8] = 8'($urandom_range(8'h41, 8'h43));
                default: key = {$urandom, $urandom};
            endcase
            write_reg(CFG_KEY_CHARS, key);
            klen = ($urandom_range(0, 3) == 0) ? 4'd8 : 4'($urandom_range(0, 15));
            write_reg(CFG_KEY_LENGTH, KEY_CHARS_W'(klen));
            write_reg(CFG_DIRECTION, KEY_CHARS_W'($urandom_range(0, 1)));
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_SPARE, {$urandom, $urandom});

            n_msgs = first_phase ? 6 : $urandom_range(2, 6);
            if (first_phase)
                hold_go = 1'b1;
            first_phase = 1'b0;

            repeat (n_msgs)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 12);
                msg_q.delete();
                if (dir_reg == DIR_DECRYPT && $urandom_range(0, 1) == 1)
                begin
                    // Proper ciphertext, so that padding removal is reached.
                    plain_len = (len > MAX_TEXT) ? MAX_TEXT : len;
                    for (int i = 0; i < plain_len; i++)
                        plain[i] = 8'($urandom);
                    transpose_msg(plain, plain_len, key_reg, klen_reg, DIR_ENCRYPT);
                    msg_q = perm_out;
                end
                else
                    for (int i = 0; i < len; i++)
                        msg_q.push_back(($urandom_range(0, 5) == 0) ? PAD_BYTE : 8'($urandom));
                send_msg();
            end
        end

        drain();
        if (errors == 0)
            $display("columnar_transposition_cipher_core regression: pass");
        else
            $display("columnar_transposition_cipher_core regression: fail");
        $finish;
    end

endmodule
